// ===== hdl/cbc_pkg.sv =====
// cbc_pkg: shared constants, codes and types for the cartridge bank controller.
// Used by cbc_mod_unit, cartridge_bank_controller, cbc_checker and the testbench; no dependencies.
`default_nettype none

package cbc_pkg;

  // Field widths
  localparam int CMD_W       = 2;
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int SEL_W       = 2;
  localparam int ROM_ADDR_W  = 23;
  localparam int RAM_ADDR_W  = 17;
  localparam int ROM_CNT_W   = 10;
  localparam int RAM_CNT_W   = 5;
  localparam int ROM_BANK_W  = 9;
  localparam int RAM_BANK_W  = 4;
  localparam int ROM_OFF_W   = 14;
  localparam int RAM_OFF_W   = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = ROM_CNT_W;

  // Remainder unit sizing: dividend is a 9-bit bank index, divisor a bank count
  localparam int DVD_W       = ROM_BANK_W;
  localparam int DVS_W       = ROM_CNT_W;
  localparam int STEP_W      = 4;

  // Bank count limits
  localparam logic [ROM_CNT_W-1:0] MAX_ROM_BANKS = 10'd512;
  localparam logic [RAM_CNT_W-1:0] MAX_RAM_BANKS = 5'd16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ROM_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REG_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RAM_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RAM_WRITE = 2'd3;

  // Select codes
  localparam logic [SEL_W-1:0] SEL_NONE      = 2'd0;
  localparam logic [SEL_W-1:0] SEL_ROM_READ  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_RAM_READ  = 2'd2;
  localparam logic [SEL_W-1:0] SEL_RAM_WRITE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 1'd1;

  // Register-write address windows
  localparam logic [ADDR_W-1:0] REG_ROM_LOW_BASE  = 16'h2000;
  localparam logic [ADDR_W-1:0] REG_ROM_HIGH_BASE = 16'h3000;
  localparam logic [ADDR_W-1:0] REG_RAM_BANK_BASE = 16'h4000;
  localparam logic [ADDR_W-1:0] REG_UNUSED_BASE   = 16'h6000;
  localparam logic [ADDR_W-1:0] ROM_SWITCH_BASE   = 16'h4000;

  // RAM enable pattern in the low nibble
  localparam logic [DATA_W-1:0] RAM_EN_MASK = 8'h0A;

  // Reset values
  localparam logic [ROM_CNT_W-1:0]  ROM_CNT_RESET  = 10'd2;
  localparam logic [RAM_CNT_W-1:0]  RAM_CNT_RESET  = 5'd0;
  localparam logic [DATA_W-1:0]     ROM_LOW_RESET  = 8'h01;
  localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 9'd1;

  // Request into the shared remainder unit
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } mod_req_t;

  // Status back from the remainder unit
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] remainder;
  } mod_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/cbc_mod_unit.sv =====
// cbc_mod_unit: shift-subtract remainder unit, one quotient bit per cycle.
// Depends on cbc_pkg for widths and the request/response structs.
`default_nettype none

module cbc_mod_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  cbc_pkg::mod_req_t      req,
  output cbc_pkg::mod_rsp_t      rsp
);
  import cbc_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  trial;
  logic [DVS_W-1:0]  rem_next;

  // Partial remainder stays below the divisor (<= 512), so 9 bits plus one shifted in
  assign trial    = {rem[DVS_W-2:0], dvd[DVD_W-1]};
  assign rem_next = (trial >= dvs) ? (trial - dvs) : trial;

  // Control: start loads operands, then DVD_W steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        step <= STEP_W'(DVD_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.remainder = rem[DVD_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/cartridge_bank_controller.sv =====
// cartridge_bank_controller: bank-switching cartridge controller, top level.
// Depends on cbc_pkg and cbc_mod_unit (shared remainder unit).
//
//  Channel  Dir  Handshake          Payload
//  s_*      in   s_tvalid/s_tready  tuser: command; tdata: address, write_data
//  m_*      out  m_tvalid/m_tready  tuser: select; tdata: rom/ram address, wdata
//  cfg_*    in   cfg_we             cfg_index, cfg_data (bank counts)
//
// Reads, RAM enable writes and ignored writes: result registered in the cycle after accept.
// ROM/RAM bank writes: result registered once the 9-step remainder unit reports done.
// One access in flight; s_tready drops until the result register is free again.
// Reset is synchronous: bank state, counts and the output valid return to defaults.
// A stalled output holds its transaction; the input waits behind it.
`default_nettype none

module cartridge_bank_controller (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output      logic                              s_tready,
  input  wire logic [23:0]                       s_tdata,  // address[15:0], write_data[23:16]
  input  wire logic [cbc_pkg::CMD_W-1:0]         s_tuser,  // command[1:0]
  output      logic                              m_tvalid,
  input  wire logic                              m_tready,
  output      logic [47:0]                       m_tdata,  // rom_address[22:0],
                                                           // ram_address[39:23],
                                                           // ram_write_data[47:40]
  output      logic [cbc_pkg::SEL_W-1:0]         m_tuser,  // select[1:0]
  input  wire logic                              cfg_we,
  input  wire logic [cbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cbc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_MOD  = 1'b1;

  logic                  state;
  logic                  tgt_ram;
  logic [ROM_CNT_W-1:0]  rom_bank_count;
  logic [RAM_CNT_W-1:0]  ram_bank_count;
  logic [DATA_W-1:0]     rom_bank_low_byte;
  logic                  rom_bank_high_bit;
  logic [ROM_BANK_W-1:0] rom_bank_selected;
  logic                  ram_enable;
  logic [RAM_BANK_W-1:0] ram_bank_selected;

  logic [SEL_W-1:0]      out_sel;
  logic [ROM_ADDR_W-1:0] out_rom;
  logic [RAM_ADDR_W-1:0] out_ram;
  logic [DATA_W-1:0]     out_wd;

  logic [CMD_W-1:0]      cmd;
  logic [ADDR_W-1:0]     addr;
  logic [DATA_W-1:0]     wdata;
  logic                  accept;
  logic [ROM_CNT_W-1:0]  eff_rom;
  logic [RAM_CNT_W-1:0]  eff_ram;
  logic                  ram_ok;
  logic                  is_rom_bank_wr;
  logic                  is_ram_bank_wr;
  logic [DVD_W-1:0]      rom_dividend;
  mod_req_t              mreq;
  mod_rsp_t              mrsp;

  assign cmd   = s_tuser;
  assign addr  = s_tdata[ADDR_W-1:0];
  assign wdata = s_tdata[ADDR_W +: DATA_W];

  assign s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // Effective bank counts: zero ROM banks means one, oversize saturates
  always_comb begin
    eff_rom = rom_bank_count;
    if (eff_rom == '0)
      eff_rom = ROM_CNT_W'(1);
    if (eff_rom > MAX_ROM_BANKS)
      eff_rom = MAX_ROM_BANKS;
    eff_ram = (ram_bank_count > MAX_RAM_BANKS) ? MAX_RAM_BANKS : ram_bank_count;
  end

  assign ram_ok = (eff_ram != '0) && ram_enable;

  // Bank-register write decode
  assign is_rom_bank_wr = (cmd == CMD_REG_WRITE) && (addr >= REG_ROM_LOW_BASE)
                          && (addr < REG_RAM_BANK_BASE);
  assign is_ram_bank_wr = (cmd == CMD_REG_WRITE) && (addr >= REG_RAM_BANK_BASE)
                          && (addr < REG_UNUSED_BASE) && (eff_ram != '0);

  // ROM bank index with the byte or bit being written merged in
  assign rom_dividend = (addr < REG_ROM_HIGH_BASE) ? {rom_bank_high_bit, wdata}
                                                   : {wdata[0], rom_bank_low_byte};

  // Remainder request: ROM count or RAM count as divisor
  always_comb begin
    mreq.start    = accept && (is_rom_bank_wr || is_ram_bank_wr);
    mreq.dividend = is_rom_bank_wr ? rom_dividend : DVD_W'(wdata);
    mreq.divisor  = is_rom_bank_wr ? eff_rom : DVS_W'(eff_ram);
  end

  cbc_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_count <= ROM_CNT_RESET;
      ram_bank_count <= RAM_CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROM_BANK_COUNT: rom_bank_count <= cfg_data;
        CFG_RAM_BANK_COUNT: ram_bank_count <= cfg_data[RAM_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, bank state and valid of the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      tgt_ram           <= 1'b0;
      rom_bank_low_byte <= ROM_LOW_RESET;
      rom_bank_high_bit <= 1'b0;
      rom_bank_selected <= ROM_BANK_RESET;
      ram_enable        <= 1'b0;
      ram_bank_selected <= '0;
      m_tvalid          <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_rom_bank_wr) begin
              if (addr < REG_ROM_HIGH_BASE)
                rom_bank_low_byte <= wdata;
              else
                rom_bank_high_bit <= wdata[0];
              tgt_ram <= 1'b0;
              state   <= ST_MOD;
            end else if (is_ram_bank_wr) begin
              tgt_ram <= 1'b1;
              state   <= ST_MOD;
            end else begin
              if ((cmd == CMD_REG_WRITE) && (addr < REG_ROM_LOW_BASE))
                ram_enable <= ((wdata & RAM_EN_MASK) == RAM_EN_MASK);
              m_tvalid <= 1'b1;
            end
          end
        end
        ST_MOD: begin
          if (mrsp.done) begin
            if (tgt_ram)
              ram_bank_selected <= mrsp.remainder[RAM_BANK_W-1:0];
            else
              rom_bank_selected <= mrsp.remainder;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == ST_MOD) begin
      if (mrsp.done) begin
        out_sel <= SEL_NONE;
        out_rom <= '0;
        out_ram <= '0;
        out_wd  <= '0;
      end
    end else if (accept) begin
      out_sel <= SEL_NONE;
      out_rom <= '0;
      out_ram <= '0;
      out_wd  <= '0;
      case (cmd) inside
        CMD_ROM_READ: begin
          out_sel <= SEL_ROM_READ;
          if (addr < ROM_SWITCH_BASE)
            out_rom <= {{ROM_BANK_W{1'b0}}, addr[ROM_OFF_W-1:0]};
          else
            out_rom <= {rom_bank_selected, addr[ROM_OFF_W-1:0]};
        end
        CMD_RAM_READ, CMD_RAM_WRITE: begin
          if (ram_ok) begin
            out_ram <= {ram_bank_selected, addr[RAM_OFF_W-1:0]};
            if (cmd == CMD_RAM_READ) begin
              out_sel <= SEL_RAM_READ;
            end else begin
              out_sel <= SEL_RAM_WRITE;
              out_wd  <= wdata;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {out_wd, out_ram, out_rom};
  assign m_tuser = out_sel;

`ifndef ASSERT_OFF
  // Remainder unit only finishes while the sequencer waits on it
  a_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> (state == ST_MOD))
    else $error("remainder done outside bank update");

  // No result is pending while a bank update is running
  a_mod_no_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |-> !m_tvalid)
    else $error("result pending during bank update");

  // A bank update ends in a no-select result
  a_done_result: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |=> (m_tvalid && (m_tuser == SEL_NONE)))
    else $error("bank update produced wrong result");

  // Unit is never restarted while busy
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    mrsp.busy |-> !mreq.start)
    else $error("remainder unit started while busy");
`endif

endmodule

`default_nettype wire

// ===== verif/cbc_checker.sv =====
// cbc_checker: watches the access, result and register-write ports of the cartridge
// bank controller, predicts each mapped result and compares it field by field.
// Depends on cbc_pkg for widths, command, select and register codes.
`default_nettype none

module cbc_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  input  wire logic                           s_tready,
  input  wire logic [23:0]                    s_tdata,   // address[15:0], write_data[23:16]
  input  wire logic [cbc_pkg::CMD_W-1:0]      s_tuser,   // command[1:0]
  input  wire logic                           m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [47:0]                    m_tdata,   // rom_address[22:0],
                                                         // ram_address[39:23],
                                                         // ram_write_data[47:40]
  input  wire logic [cbc_pkg::SEL_W-1:0]      m_tuser,   // select[1:0]
  input  wire logic                           cfg_we,
  input  wire logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  errors,
  output int                                  outstanding,
  output int                                  checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import cbc_pkg::*;

  localparam logic [ADDR_W-1:0] RAM_WINDOW_BASE = 16'hA000;
  localparam int                PRINT_CAP       = 40;

  typedef struct packed {
    logic [SEL_W-1:0]      sel;
    logic [ROM_ADDR_W-1:0] rom_addr;
    logic [RAM_ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0]     wdata;
  } bus_map_t;

  // Shadow copy of the bank counts and bank-switch registers
  logic [ROM_CNT_W-1:0]  rom_count;
  logic [RAM_CNT_W-1:0]  ram_count;
  logic [DATA_W-1:0]     rom_low;
  logic                  rom_high;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic                  ram_on;
  logic [RAM_BANK_W-1:0] ram_bank;

  bus_map_t expected_maps[$];

  initial begin
    errors      = 0;
    outstanding = 0;
    checked     = 0;
  end

  // Zero ROM banks act as one; oversized counts clamp to the maximum
  function automatic int unsigned rom_banks_in_use();
    int unsigned c;
    c = rom_count;
    if (c == 0) c = 1;
    if (c > MAX_ROM_BANKS) c = MAX_ROM_BANKS;
    return c;
  endfunction

  function automatic int unsigned ram_banks_in_use();
    int unsigned c;
    c = ram_count;
    if (c > MAX_RAM_BANKS) c = MAX_RAM_BANKS;
    return c;
  endfunction

  // Map one bus access and apply its side effects on the bank registers
  function automatic bus_map_t map_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                          logic [DATA_W-1:0] data);
    bus_map_t    r;
    logic [15:0] off;
    int unsigned q;
    r = '0;
    case (cmd)
      CMD_ROM_READ: begin
        r.sel = SEL_ROM_READ;
        if (addr < ROM_SWITCH_BASE) begin
          r.rom_addr = {9'd0, addr[13:0]};
        end else begin
          off        = addr - ROM_SWITCH_BASE;
          r.rom_addr = {rom_bank, off[13:0]};
        end
      end
      CMD_REG_WRITE: begin
        if (addr < REG_ROM_LOW_BASE) begin
          ram_on = ((data & RAM_EN_MASK) == RAM_EN_MASK);
        end else if (addr < REG_RAM_BANK_BASE) begin
          if (addr < REG_ROM_HIGH_BASE) rom_low = data;
          else rom_high = data[0];
          q        = {rom_high, rom_low};
          q        = q % rom_banks_in_use();
          rom_bank = q[8:0];
        end else if (addr < REG_UNUSED_BASE) begin
          // bank write is dropped when the cartridge has no RAM
          if (ram_banks_in_use() != 0) begin
            q        = data;
            q        = q % ram_banks_in_use();
            ram_bank = q[3:0];
          end
        end
      end
      default: begin
        // RAM access: nothing selected when disabled or absent
        if (ram_banks_in_use() != 0 && ram_on) begin
          off        = addr - RAM_WINDOW_BASE;
          r.ram_addr = {ram_bank, off[12:0]};
          if (cmd == CMD_RAM_READ) begin
            r.sel = SEL_RAM_READ;
          end else begin
            r.sel   = SEL_RAM_WRITE;
            r.wdata = data;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Compare first, then take register writes and new accesses
  always @(posedge clk) begin
    bus_map_t want;
    bus_map_t got;
    if (rst) begin
      rom_count = ROM_CNT_RESET;
      ram_count = RAM_CNT_RESET;
      rom_low   = ROM_LOW_RESET;
      rom_high  = 1'b0;
      rom_bank  = ROM_BANK_RESET;
      ram_on    = 1'b0;
      ram_bank  = '0;
      expected_maps.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.sel      = m_tuser;
        got.rom_addr = m_tdata[22:0];
        got.ram_addr = m_tdata[39:23];
        got.wdata    = m_tdata[47:40];
        if (expected_maps.size() == 0) begin
          report($sformatf("result with nothing pending: select %0d", got.sel));
        end else begin
          want = expected_maps.pop_front();
          checked++;
          if (got.sel != want.sel)
            report($sformatf("select got %0d want %0d", got.sel, want.sel));
          if (got.rom_addr != want.rom_addr)
            report($sformatf("rom_address got %06h want %06h", got.rom_addr, want.rom_addr));
          if (got.ram_addr != want.ram_addr)
            report($sformatf("ram_address got %05h want %05h", got.ram_addr, want.ram_addr));
          if (got.wdata != want.wdata)
            report($sformatf("ram_write_data got %02h want %02h", got.wdata, want.wdata));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_ROM_BANK_COUNT) rom_count = cfg_data;
        else ram_count = cfg_data[RAM_CNT_W-1:0];
      end
      if (s_tvalid && s_tready)
        expected_maps.push_back(map_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
    end
    outstanding <= expected_maps.size();
  end

endmodule

`default_nettype wire

// ===== verif/tb_cartridge_bank_controller.sv =====
// tb_cartridge_bank_controller: drives bus accesses, bank-count writes and result
// back-pressure into the cartridge bank controller; cbc_checker does the checking.
// Depends on cbc_pkg, cartridge_bank_controller and cbc_checker.
`default_nettype none

module tb_cartridge_bank_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import cbc_pkg::*;

  localparam int DRAIN_CYCLES  = 16;
  localparam int SEGMENTS      = 4;
  localparam int SEGMENT_ITEMS = 125;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [23:0]           s_tdata;   // address[15:0], write_data[23:16]
  logic [CMD_W-1:0]      s_tuser;   // command[1:0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [47:0]           m_tdata;   // rom_address[22:0], ram_address[39:23],
                                    // ram_write_data[47:40]
  logic [SEL_W-1:0]      m_tuser;   // select[1:0]
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending_maps;
  int results_seen;
  int send_idle_pct;
  int ready_stall_pct;
  int settings_used;

  cartridge_bank_controller u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  cbc_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (fail_count),
    .outstanding(pending_maps),
    .checked    (results_seen)
  );

  initial begin
    clk = 1'b0;
  end
  always #10 clk = ~clk;

  // Result side back-pressure
  always @(negedge clk) m_tready <= ($urandom_range(99) >= ready_stall_pct);

  // One access transaction, with a random lead-in gap
  task automatic send(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      s_tuser  <= CMD_W'($urandom);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {data, addr};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and let every pending result come out
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_maps != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_banks(int unsigned rom_n, int unsigned ram_n);
    drain();
    write_cfg(CFG_ROM_BANK_COUNT, CFG_DATA_W'(rom_n));
    write_cfg(CFG_RAM_BANK_COUNT, CFG_DATA_W'(ram_n));
    settings_used++;
  endtask

  // Mostly real cartridge windows, with some fully random addresses
  task automatic random_access();
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    int unsigned       pick;
    pick = $urandom_range(99);
    data = DATA_W'($urandom);
    if (pick < 30) begin
      cmd  = CMD_ROM_READ;
      addr = ($urandom_range(3) == 0) ? ADDR_W'($urandom)
                                      : ROM_SWITCH_BASE + ADDR_W'($urandom_range(16'h3FFF));
    end else if (pick < 55) begin
      cmd = CMD_REG_WRITE;
      case ($urandom_range(5))
        0: begin
          addr = ADDR_W'($urandom_range(16'h1FFF));
          if ($urandom_range(1) == 1) data = data | RAM_EN_MASK;
        end
        1: addr = REG_ROM_LOW_BASE + ADDR_W'($urandom_range(16'h0FFF));
        2: addr = REG_ROM_HIGH_BASE + ADDR_W'($urandom_range(16'h0FFF));
        3: addr = REG_RAM_BANK_BASE + ADDR_W'($urandom_range(16'h1FFF));
        4: addr = REG_UNUSED_BASE + ADDR_W'($urandom_range(16'h9FFF));
        default: addr = ADDR_W'($urandom);
      endcase
    end else begin
      cmd  = (pick < 78) ? CMD_RAM_READ : CMD_RAM_WRITE;
      addr = ($urandom_range(3) == 0) ? ADDR_W'($urandom)
                                      : 16'hA000 + ADDR_W'($urandom_range(16'h1FFF));
    end
    send(cmd, addr, data);
  endtask

  function automatic int unsigned pick_rom_count();
    case ($urandom_range(7))
      0: return 0;
      1: return 1023;
      2: return 512;
      3: return 1;
      4, 5: return 1 << $urandom_range(9);
      default: return $urandom_range(1023);
    endcase
  endfunction

  function automatic int unsigned pick_ram_count();
    case ($urandom_range(5))
      0: return 0;
      1: return 16;
      2: return 31;
      3: return 1 << $urandom_range(4);
      default: return $urandom_range(31);
    endcase
  endfunction

  // Hard stop
  initial begin
    #20_000_000;
    $display("[cartridge_bank_controller] ERROR");
    $finish;
  end

  initial begin
    int idle_modes[4];
    int stall_modes[4];
    idle_modes  = '{0, 82, 0, 18};
    stall_modes = '{0, 0, 82, 18};
    rst             = 1'b1;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    s_tuser         = CMD_ROM_READ;
    m_tready        = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_ROM_BANK_COUNT;
    cfg_data        = '0;
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    settings_used   = 1;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Reset counts: two ROM banks, no RAM
    send(CMD_ROM_READ, 16'h0000, 8'h00);
    send(CMD_ROM_READ, 16'h7FFF, 8'h00);
    send(CMD_ROM_READ, 16'hFFFF, 8'hFF);      // offset wraps past the ROM window
    send(CMD_RAM_READ, 16'hA000, 8'h00);      // no RAM fitted
    send(CMD_REG_WRITE, 16'h0000, 8'h0A);
    send(CMD_RAM_WRITE, 16'hBFFF, 8'h5A);     // enabled but still no RAM
    send(CMD_REG_WRITE, 16'h4000, 8'h03);     // RAM bank write without RAM
    send(CMD_REG_WRITE, 16'h6000, 8'hFF);     // unused register window
    send(CMD_REG_WRITE, 16'hFFFF, 8'h00);

    // Zero ROM banks act as one bank
    set_banks(0, 16);
    send(CMD_REG_WRITE, 16'h2000, 8'hFF);
    send(CMD_ROM_READ, 16'h4000, 8'h00);
    send(CMD_REG_WRITE, 16'h5FFF, 8'hFF);
    send(CMD_RAM_WRITE, 16'hA000, 8'hFF);
    send(CMD_RAM_READ, 16'h0000, 8'h00);      // RAM offset wraps below the window
    send(CMD_RAM_READ, 16'hFFFF, 8'h00);
    send(CMD_REG_WRITE, 16'h1FFF, 8'h08);     // only one enable bit: disables
    send(CMD_RAM_READ, 16'hBFFF, 8'h00);

    // Oversized counts clamp to the maximum
    set_banks(1023, 31);
    send(CMD_REG_WRITE, 16'h3FFF, 8'hFF);
    send(CMD_ROM_READ, 16'hFFFF, 8'h00);
    send(CMD_REG_WRITE, 16'h0000, 8'hFF);
    send(CMD_REG_WRITE, 16'h4000, 8'h13);
    send(CMD_RAM_WRITE, 16'hBFFF, 8'h00);

    // Count shrinks after a bank write: stored bank stays until rewritten
    set_banks(3, 31);
    send(CMD_ROM_READ, 16'h7FFF, 8'h00);
    send(CMD_REG_WRITE, 16'h2000, 8'h00);
    send(CMD_ROM_READ, 16'h8000, 8'h00);

    // Random traffic under each pacing mode
    for (int p = 0; p < 4; p++) begin
      send_idle_pct   = idle_modes[p];
      ready_stall_pct = stall_modes[p];
      for (int s = 0; s < SEGMENTS; s++) begin
        set_banks(pick_rom_count(), pick_ram_count());
        for (int i = 0; i < SEGMENT_ITEMS; i++) begin
          if ($urandom_range(99) == 0) drain();
          random_access();
        end
      end
    end

    drain();
    $display("Checked %0d mapped accesses over %0d bank-count settings,", results_seen,
             settings_used);
    $display("with free-running, sender-idle, receiver-stall and mixed pacing.");
    if (fail_count == 0) begin
      $display("[cartridge_bank_controller] OK");
    end else begin
      $display("[cartridge_bank_controller] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== cartridge_bank_controller.f =====
hdl/cbc_pkg.sv
hdl/cbc_mod_unit.sv
hdl/cartridge_bank_controller.sv
verif/cbc_checker.sv
verif/tb_cartridge_bank_controller.sv
